>>> src/rtlb_pkg.sv
`default_nettype none

package rtlb_pkg;

   // Field widths of the request and response items.
   localparam int OPCODE_W  = 2;
   localparam int KEY_W     = 32;
   localparam int WEIGHT_W  = 16;
   localparam int LIMIT_W   = 16;
   localparam int TIMEOUT_W = 32;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 4;
   localparam int LIVE_W    = 5;
   localparam int TOTAL_W   = 64;
   localparam int MODE_W    = 2;

   // Defaults for the top-level parameters.
   localparam int SLOTS_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT = 32;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_REGISTER   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_UNREGISTER = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOOKUP     = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_ROUTE      = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_ROUTE  = 3'd5;

   // Selection modes; every mode other than round robin takes the lowest enabled slot.
   localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd0;

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic [KEY_W-1:0]     route_key;
      logic [WEIGHT_W-1:0]  route_weight;
      logic [LIMIT_W-1:0]   concurrency_limit;
      logic [TIMEOUT_W-1:0] route_timeout;
      logic                 start_enabled;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [KEY_W-1:0]     out_key;
      logic [SLOT_W-1:0]    out_slot;
      logic [WEIGHT_W-1:0]  out_weight;
      logic [LIMIT_W-1:0]   out_limit;
      logic [TIMEOUT_W-1:0] out_timeout;
      logic                 out_enabled;
      logic [LIVE_W-1:0]    live_routes;
      logic [TOTAL_W-1:0]   routed_total;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;    // capture the request and clear the scan results
      logic issue;   // read the next slot of the scan
      logic finish;  // commit the table update and load the response
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_last;  // the slot read this cycle is the last of the scan
   } sts_type;

endpackage

`default_nettype wire

>>> src/rtlb_ram.sv
`default_nettype none

module rtlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/rtlb_ctrl.sv
`default_nettype none

module rtlb_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire rtlb_pkg::sts_type sts,
   output rtlb_pkg::cmd_type     cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_LAST   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.scan_last) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            // The read data of the last slot is evaluated in this cycle.
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> src/rtlb_datapath.sv
`default_nettype none

module rtlb_datapath #(
   parameter int SLOTS    = rtlb_pkg::SLOTS_DEFAULT,
   parameter int KEY_BITS = rtlb_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [rtlb_pkg::MODE_W-1:0]  csr_wr_data,
   input  wire rtlb_pkg::req_type            req_data,
   input  wire rtlb_pkg::cmd_type            cmd,
   output rtlb_pkg::sts_type                 sts,
   output rtlb_pkg::rsp_type                 rsp_data
);

   localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CntW  = $clog2(SLOTS + 1);
   localparam int KeyW  = (KEY_BITS < rtlb_pkg::KEY_W) ? KEY_BITS : rtlb_pkg::KEY_W;
   localparam int TmoLo = 0;
   localparam int LimLo = TmoLo + rtlb_pkg::TIMEOUT_W;
   localparam int WgtLo = LimLo + rtlb_pkg::LIMIT_W;
   localparam int KeyLo = WgtLo + rtlb_pkg::WEIGHT_W;
   localparam int EntW  = KeyLo + KeyW;
   localparam logic [IdxW:0]   SlotsC   = (IdxW + 1)'(SLOTS);
   localparam logic [IdxW-1:0] LastSlot = IdxW'(SLOTS - 1);

   logic [rtlb_pkg::MODE_W-1:0] mode_ff, mode_in;
   rtlb_pkg::req_type           req_ff, req_in;
   logic [IdxW-1:0]             cnt_ff, cnt_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic [IdxW-1:0]             rd_idx_ff, rd_idx_in;
   logic                        found_ff, found_in;
   logic [IdxW-1:0]             hit_idx_ff, hit_idx_in;
   logic [EntW-1:0]             hit_data_ff, hit_data_in;
   logic                        free_ff, free_in;
   logic [IdxW-1:0]             free_idx_ff, free_idx_in;
   logic [SLOTS-1:0]            occ_ff, occ_in;
   logic [SLOTS-1:0]            en_ff, en_in;
   logic [CntW-1:0]             live_ff, live_in;
   logic [rtlb_pkg::TOTAL_W-1:0] routed_ff, routed_in;
   logic [IdxW-1:0]             ptr_ff, ptr_in;
   rtlb_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        is_route;
   logic [IdxW-1:0]             start_idx;
   logic [IdxW:0]               addr_sum;
   logic [IdxW-1:0]             rd_addr;
   logic [EntW-1:0]             rd_data;
   logic                        wr_en;
   logic [IdxW-1:0]             wr_addr;
   logic [EntW-1:0]             wr_data;
   logic [KeyW-1:0]             req_key;
   logic                        slot_hit;

   assign is_route = (req_ff.opcode == rtlb_pkg::OP_ROUTE);
   assign req_key  = req_ff.route_key[KeyW-1:0];

   // Round robin starts at the pointer, every other scan at slot zero.
   assign start_idx = (is_route && mode_ff == rtlb_pkg::MODE_ROUND_ROBIN) ? ptr_ff : '0;
   assign addr_sum  = {1'b0, start_idx} + {1'b0, cnt_ff};
   assign rd_addr   = (addr_sum >= SlotsC) ? IdxW'(addr_sum - SlotsC) : addr_sum[IdxW-1:0];

   assign sts.scan_last = (cnt_ff == LastSlot);

   rtlb_ram #(
      .WIDTH (EntW),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_data = {req_key, req_ff.route_weight, req_ff.concurrency_limit,
                     req_ff.route_timeout};

   // Scan: one slot read issued per cycle, evaluated when its data returns.
   always_comb begin
      mode_in     = csr_wr_en ? csr_wr_data : mode_ff;
      req_in      = cmd.load ? req_data : req_ff;
      cnt_in      = cnt_ff;
      rd_valid_in = cmd.issue;
      rd_idx_in   = rd_addr;
      found_in    = found_ff;
      hit_idx_in  = hit_idx_ff;
      hit_data_in = hit_data_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      slot_hit    = 1'b0;

      if (is_route) begin
         slot_hit = occ_ff[rd_idx_ff] && en_ff[rd_idx_ff];
      end else begin
         slot_hit = occ_ff[rd_idx_ff] && (rd_data[KeyLo +: KeyW] == req_key);
      end

      if (cmd.load) begin
         cnt_in   = '0;
         found_in = 1'b0;
         free_in  = 1'b0;
      end else begin
         if (cmd.issue) begin
            cnt_in = cnt_ff + IdxW'(1);
         end
         if (rd_valid_ff && slot_hit && !found_ff) begin
            found_in    = 1'b1;
            hit_idx_in  = rd_idx_ff;
            hit_data_in = rd_data;
         end
         if (rd_valid_ff && !occ_ff[rd_idx_ff] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end
   end

   // Commit: decide the status, update the table and build the response.
   always_comb begin
      logic [CntW+rtlb_pkg::LIVE_W-1:0] live_ext;
      logic [IdxW+rtlb_pkg::SLOT_W-1:0] slot_ext;
      logic [KeyW+rtlb_pkg::KEY_W-1:0]  key_ext;
      logic [IdxW-1:0]                  slot_sel;

      occ_in    = occ_ff;
      en_in     = en_ff;
      live_in   = live_ff;
      routed_in = routed_ff;
      ptr_in    = ptr_ff;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      wr_addr   = free_idx_ff;
      slot_sel  = '0;
      live_ext  = '0;
      slot_ext  = '0;
      key_ext   = '0;

      if (cmd.finish) begin
         rsp_in        = '0;
         rsp_in.status = rtlb_pkg::ST_OK;
         unique case (req_ff.opcode)
            rtlb_pkg::OP_REGISTER: begin
               if (req_key == '0 || req_ff.route_weight == '0 ||
                   req_ff.concurrency_limit == '0) begin
                  rsp_in.status = rtlb_pkg::ST_INVALID;
               end else if (found_ff) begin
                  rsp_in.status = rtlb_pkg::ST_EXISTS;
                  slot_sel      = hit_idx_ff;
               end else if (!free_ff) begin
                  rsp_in.status = rtlb_pkg::ST_FULL;
               end else begin
                  wr_en               = 1'b1;
                  occ_in[free_idx_ff] = 1'b1;
                  en_in[free_idx_ff]  = req_ff.start_enabled;
                  live_in             = live_ff + CntW'(1);
                  slot_sel            = free_idx_ff;
               end
            end
            rtlb_pkg::OP_UNREGISTER: begin
               if (!found_ff) begin
                  rsp_in.status = rtlb_pkg::ST_NOT_FOUND;
               end else begin
                  occ_in[hit_idx_ff] = 1'b0;
                  en_in[hit_idx_ff]  = 1'b0;
                  live_in            = live_ff - CntW'(1);
                  slot_sel           = hit_idx_ff;
               end
            end
            rtlb_pkg::OP_LOOKUP: begin
               if (!found_ff) begin
                  rsp_in.status = rtlb_pkg::ST_NOT_FOUND;
               end else begin
                  slot_sel           = hit_idx_ff;
                  rsp_in.out_weight  = hit_data_ff[WgtLo +: rtlb_pkg::WEIGHT_W];
                  rsp_in.out_limit   = hit_data_ff[LimLo +: rtlb_pkg::LIMIT_W];
                  rsp_in.out_timeout = hit_data_ff[TmoLo +: rtlb_pkg::TIMEOUT_W];
                  rsp_in.out_enabled = en_ff[hit_idx_ff];
               end
            end
            rtlb_pkg::OP_ROUTE: begin
               if (live_ff == '0) begin
                  rsp_in.status = rtlb_pkg::ST_NO_ROUTE;
               end else begin
                  // The pointer moves even when no enabled slot turns up.
                  if (mode_ff == rtlb_pkg::MODE_ROUND_ROBIN) begin
                     ptr_in = (ptr_ff == LastSlot) ? '0 : ptr_ff + IdxW'(1);
                  end
                  if (!found_ff) begin
                     rsp_in.status = rtlb_pkg::ST_NO_ROUTE;
                  end else begin
                     routed_in = routed_ff + rtlb_pkg::TOTAL_W'(1);
                     slot_sel  = hit_idx_ff;
                  end
               end
            end
            default: begin
               rsp_in.status = rtlb_pkg::ST_OK;
            end
         endcase

         key_ext  = {{rtlb_pkg::KEY_W{1'b0}}, hit_data_ff[KeyLo +: KeyW]};
         slot_ext = {{rtlb_pkg::SLOT_W{1'b0}}, slot_sel};
         live_ext = {{rtlb_pkg::LIVE_W{1'b0}}, live_in};
         if (found_ff && (req_ff.opcode == rtlb_pkg::OP_LOOKUP ||
                          (is_route && live_ff != '0))) begin
            rsp_in.out_key = key_ext[rtlb_pkg::KEY_W-1:0];
         end
         rsp_in.out_slot     = slot_ext[rtlb_pkg::SLOT_W-1:0];
         rsp_in.live_routes  = live_ext[rtlb_pkg::LIVE_W-1:0];
         rsp_in.routed_total = routed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= rtlb_pkg::MODE_ROUND_ROBIN;
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
         occ_ff      <= '0;
         en_ff       <= '0;
         live_ff     <= '0;
         routed_ff   <= '0;
         ptr_ff      <= '0;
      end else begin
         mode_ff     <= mode_in;
         cnt_ff      <= cnt_in;
         rd_valid_ff <= rd_valid_in;
         found_ff    <= found_in;
         free_ff     <= free_in;
         occ_ff      <= occ_in;
         en_ff       <= en_in;
         live_ff     <= live_in;
         routed_ff   <= routed_in;
         ptr_ff      <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rd_idx_ff   <= rd_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_data_ff <= hit_data_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> src/route_table_load_balancer_core.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  rtlb_pkg::req_type
// rsp_      out        rsp_valid / rsp_stall  rtlb_pkg::rsp_type
// csr_      in         csr_wr_en              route_mode (csr_wr_data)
//
// A request is taken only in the idle state, so the next one waits until it is done:
// the slot table sits in a single-read-port memory that is scanned one slot
// per cycle, followed by a state for the last read, a commit state and the
// idle state that takes the next request. Reset is synchronous and active
// high; it empties the table at once, since occupancy and enable marks live
// in flip-flops, so no clearing pass follows reset. A stalled response holds
// the commit of the next request, while the next request itself is still
// taken and scanned.
`default_nettype none

module route_table_load_balancer_core #(
   parameter int SLOTS    = rtlb_pkg::SLOTS_DEFAULT,
   parameter int KEY_BITS = rtlb_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire rtlb_pkg::req_type           req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output rtlb_pkg::rsp_type                rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [rtlb_pkg::MODE_W-1:0] csr_wr_data
);

   // The controller sequences each request through load, scan, drain and
   // commit; the datapath holds the table, the scan results and the counters.
   rtlb_pkg::cmd_type cmd;
   rtlb_pkg::sts_type sts;

   rtlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rtlb_datapath #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

   // The commit never overwrites a response that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

   // A commit always presents a response in the next cycle.
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("commit without response");

   // Once a request is taken, the input stays closed while it is processed.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken during processing");

   // Load, scan and commit commands are mutually exclusive.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.issue, cmd.finish}))
      else $error("overlapping controller commands");

endmodule

`default_nettype wire
